/* design/slrl_pkg.sv */
// slrl_pkg: shared types and constants for the session log rate limiter.
// Used by slrl_ctrl, slrl_dp and session_log_rate_limiter; no dependencies.
`default_nettype none
package slrl_pkg;

   localparam int SESSIONS    = 64;
   localparam int SESS_W      = $clog2(SESSIONS);
   localparam int QUEUE_DEPTH = 256;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int FILL_W      = PTR_W + 1;
   localparam int TIME_W      = 48;
   localparam int TOK_W       = 26;
   localparam int TAG_W       = 32;
   localparam int CNT_W       = 32;
   localparam int RATE_W      = 16;
   localparam int BURST_W     = 16;
   localparam int LIMIT_W     = 9;
   localparam int STATUS_W    = 3;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int PROD_W      = RATE_W + TOK_W;
   localparam int SUM_W       = PROD_W + 1;
   localparam int REQ_TDATA_W = 88;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 112;

   localparam logic [TOK_W-1:0] MILLI = TOK_W'(1000);

   localparam logic [STATUS_W-1:0] ST_ADMIT      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ADMIT_DROP = 3'd1;
   localparam logic [STATUS_W-1:0] ST_LIMITED    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_TAKEN      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_RATE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BURST = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT = 2'd2;

   localparam logic [RATE_W-1:0]  RATE_RST  = 16'd100;
   localparam logic [BURST_W-1:0] BURST_RST = 16'd10;
   localparam logic [LIMIT_W-1:0] LIMIT_RST = 9'd256;

   localparam logic OP_SUBMIT = 1'b0;
   localparam logic OP_TAKE   = 1'b1;

   typedef struct packed {
      logic [TIME_W-1:0] last;
      logic [TOK_W-1:0]  tokens;
   } bucket_type;

   typedef struct packed {
      logic accept;
      logic rd;
      logic eval;
      logic mul;
      logic upd;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic sess_path;
      logic slot_free;
   } dp_status_type;

endpackage
`default_nettype wire

/* design/slrl_ram.sv */
// slrl_ram: generic one-write, one-read RAM with registered read data.
// No dependencies.
`default_nettype none
module slrl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end

endmodule
`default_nettype wire

/* design/slrl_ctrl.sv */
// slrl_ctrl: sequencer for the rate limiter; issues per-step commands to slrl_dp.
// Depends on slrl_pkg.
`default_nettype none
module slrl_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire slrl_pkg::dp_status_type status,
   output slrl_pkg::ctrl_cmd_type       cmd
);
   import slrl_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_RD     = 3'd1;
   localparam logic [2:0] S_EVAL   = 3'd2;
   localparam logic [2:0] S_MUL    = 3'd3;
   localparam logic [2:0] S_UPD    = 3'd4;
   localparam logic [2:0] S_COMMIT = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      cmd        = '0;
      cmd.accept = req_tready && req_tvalid;
      cmd.rd     = (state_ff == S_RD);
      cmd.eval   = (state_ff == S_EVAL);
      cmd.mul    = (state_ff == S_MUL);
      cmd.upd    = (state_ff == S_UPD);
      cmd.commit = (state_ff == S_COMMIT) && status.slot_free;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_RD;
         end
         S_RD: begin
            state_in = status.sess_path ? S_EVAL : S_COMMIT;
         end
         S_EVAL:   state_in = S_MUL;
         S_MUL:    state_in = S_UPD;
         S_UPD:    state_in = S_COMMIT;
         S_COMMIT: begin
            if (status.slot_free) state_in = S_IDLE;
         end
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   ap_commit_to_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> (state_ff == S_IDLE))
      else $error("commit did not return to idle");

endmodule
`default_nettype wire

/* design/slrl_dp.sv */
// slrl_dp: datapath; config registers, bucket table, event ring, counters, result register.
// Depends on slrl_pkg and slrl_ram.
`default_nettype none
module slrl_dp (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire slrl_pkg::ctrl_cmd_type               cmd,
   output slrl_pkg::dp_status_type                   status,
   input  wire logic [slrl_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  wire logic [slrl_pkg::REQ_TUSER_W-1:0]     req_tuser,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic      [slrl_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic      [slrl_pkg::STATUS_W-1:0]        rsp_tuser,
   input  wire logic                                 csr_wen,
   input  wire logic [slrl_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [slrl_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import slrl_pkg::*;

   // config
   logic [RATE_W-1:0]  rate_ff;
   logic [BURST_W-1:0] burst_ff;
   logic [LIMIT_W-1:0] limit_ff;

   // latched request
   logic              op_ff;
   logic              has_ff;
   logic [SESS_W-1:0] sidx_ff;
   logic [TIME_W-1:0] now_ff;
   logic [TAG_W-1:0]  tag_ff;

   // bucket pipeline
   logic [TOK_W-1:0]  cap_ff;
   logic [TOK_W-1:0]  t_ff,    t_in;
   logic [TIME_W-1:0] last_ff, last_in;
   logic [TOK_W-1:0]  el_ff;
   logic              adv_ff, big_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [TOK_W-1:0]  t2_ff,   t2_in;
   logic [TIME_W-1:0] elapsed;
   logic [SUM_W-1:0]  sum;

   // queue and counters
   logic [SESSIONS-1:0] valid_ff;
   logic [PTR_W-1:0]    head_ff,  head_in;
   logic [FILL_W-1:0]   fill_ff,  fill_in;
   logic [CNT_W-1:0]    drop_ff,  drop_in;
   logic [CNT_W-1:0]    limc_ff,  limc_in;

   // result register
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [TAG_W-1:0]    rsp_tag_ff,    rsp_tag_in;
   logic [CNT_W-1:0]    rsp_drop_ff, rsp_limc_ff;
   logic [FILL_W-1:0]   rsp_fill_ff;

   bucket_type          bk_rdata, bk_wdata;
   logic                bk_we;
   logic [TAG_W-1:0]    ring_rdata;
   logic                ring_we;
   logic [PTR_W-1:0]    ring_waddr;

   logic                sess_path, ok, admitted, full;
   logic [LIMIT_W-1:0]  lim;

   slrl_ram #(.WIDTH($bits(bucket_type)), .DEPTH(SESSIONS)) u_bucket_ram (
      .clock (clock),
      .we    (bk_we),
      .waddr (sidx_ff),
      .wdata (bk_wdata),
      .re    (cmd.rd),
      .raddr (sidx_ff),
      .rdata (bk_rdata)
   );

   slrl_ram #(.WIDTH(TAG_W), .DEPTH(QUEUE_DEPTH)) u_ring_ram (
      .clock (clock),
      .we    (ring_we),
      .waddr (ring_waddr),
      .wdata (tag_ff),
      .re    (cmd.rd),
      .raddr (head_ff),
      .rdata (ring_rdata)
   );

   assign sess_path        = (op_ff == OP_SUBMIT) && has_ff;
   assign status.sess_path = sess_path;
   assign status.slot_free = !rsp_valid_ff || rsp_tready;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff  <= RATE_RST;
         burst_ff <= BURST_RST;
         limit_ff <= LIMIT_RST;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_RATE:  rate_ff  <= csr_wdata;
            CSR_BURST: burst_ff <= csr_wdata;
            CSR_LIMIT: limit_ff <= csr_wdata[LIMIT_W-1:0];
            default:   ;
         endcase
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff   <= req_tuser[0];
         has_ff  <= req_tuser[1];
         sidx_ff <= req_tdata[5:0];
         now_ff  <= req_tdata[53:6];
         tag_ff  <= req_tdata[85:54];
      end
   end

   // bucket evaluation: first use fills to capacity and stamps max(now,1)
   always_comb begin
      if (valid_ff[sidx_ff]) begin
         last_in = bk_rdata.last;
         t_in    = bk_rdata.tokens;
      end else begin
         last_in = (now_ff == '0) ? TIME_W'(1) : now_ff;
         t_in    = cap_ff;
      end
      elapsed = now_ff - last_in;
   end

   // refill, capped at capacity
   always_comb begin
      sum   = SUM_W'(t_ff) + SUM_W'(prod_ff);
      t2_in = t_ff;
      if (adv_ff) begin
         if (big_ff) begin
            if (rate_ff != '0 || t_ff > cap_ff) t2_in = cap_ff;
         end else if (sum > SUM_W'(cap_ff)) begin
            t2_in = cap_ff;
         end else begin
            t2_in = sum[TOK_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         cap_ff <= TOK_W'(burst_ff) * MILLI;
      end
      if (cmd.eval) begin
         t_ff    <= t_in;
         last_ff <= last_in;
         el_ff   <= elapsed[TOK_W-1:0];
         adv_ff  <= now_ff > last_in;
         big_ff  <= |elapsed[TIME_W-1:TOK_W];
      end
      if (cmd.mul) begin
         prod_ff <= PROD_W'(rate_ff) * PROD_W'(el_ff);
      end
      if (cmd.upd) begin
         t2_ff <= t2_in;
      end
   end

   // commit: bucket write-back, queue update, result
   always_comb begin
      ok        = t2_ff >= MILLI;
      admitted  = (op_ff == OP_SUBMIT) && (!has_ff || ok);
      bk_we     = cmd.commit && sess_path;
      bk_wdata.last   = adv_ff ? now_ff : last_ff;
      bk_wdata.tokens = ok ? (t2_ff - MILLI) : t2_ff;

      if (limit_ff == '0) begin
         lim = LIMIT_W'(1);
      end else if (limit_ff > LIMIT_W'(QUEUE_DEPTH)) begin
         lim = LIMIT_W'(QUEUE_DEPTH);
      end else begin
         lim = limit_ff;
      end
      full = LIMIT_W'(fill_ff) >= lim;

      // drop-oldest advances head and leaves fill unchanged, so the tail slot moves on by one
      ring_waddr = head_ff + fill_ff[PTR_W-1:0];
      ring_we    = cmd.commit && admitted;

      head_in       = head_ff;
      fill_in       = fill_ff;
      drop_in       = drop_ff;
      limc_in       = limc_ff;
      rsp_status_in = ST_ADMIT;
      rsp_tag_in    = '0;
      if (op_ff == OP_TAKE) begin
         if (fill_ff == '0) begin
            rsp_status_in = ST_EMPTY;
         end else begin
            rsp_status_in = ST_TAKEN;
            rsp_tag_in    = ring_rdata;
            head_in       = head_ff + PTR_W'(1);
            fill_in       = fill_ff - FILL_W'(1);
         end
      end else if (!admitted) begin
         rsp_status_in = ST_LIMITED;
         limc_in       = (limc_ff == '1) ? limc_ff : limc_ff + CNT_W'(1);
      end else if (full) begin
         rsp_status_in = ST_ADMIT_DROP;
         head_in       = head_ff + PTR_W'(1);
         drop_in       = (drop_ff == '1) ? drop_ff : drop_ff + CNT_W'(1);
      end else begin
         fill_in       = fill_ff + FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         head_ff      <= '0;
         fill_ff      <= '0;
         drop_ff      <= '0;
         limc_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (bk_we) valid_ff[sidx_ff] <= 1'b1;
         if (cmd.commit) begin
            head_ff      <= head_in;
            fill_ff      <= fill_in;
            drop_ff      <= drop_in;
            limc_ff      <= limc_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_status_ff <= rsp_status_in;
         rsp_tag_ff    <= rsp_tag_in;
         rsp_drop_ff   <= drop_in;
         rsp_limc_ff   <= limc_in;
         rsp_fill_ff   <= fill_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {7'b0, rsp_fill_ff, rsp_limc_ff, rsp_drop_ff, rsp_tag_ff};

   ap_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(QUEUE_DEPTH))
      else $error("ring fill above depth");

   ap_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.commit))
      else $error("result raised without commit");

   ap_tag_only_on_take: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_TAKEN) |-> (rsp_tag_ff == '0))
      else $error("nonzero tag on non-take result");

   ap_limit_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (limc_ff >= $past(limc_ff)))
      else $error("limited counter decreased");

endmodule
`default_nettype wire

/* design/session_log_rate_limiter.sv */
// session_log_rate_limiter: top level; per-session token bucket ahead of a drop-oldest queue.
// Depends on slrl_pkg, slrl_ctrl, slrl_dp, slrl_ram.
//
//   port group   dir   tdata / tuser contents
//   req_*        in    tdata: session_index, now_ms, event_tag; tuser: op, has_session
//   rsp_*        out   tdata: taken_tag, dropped_count, limited_count, queue_fill; tuser: status
//   csr_*        in    write enable, register index 0..2, write data
//
// Take or sessionless submit: accept, RAM read, commit.
// Session submit: accept, read, evaluate, refill multiply, cap, commit.
// One transaction in flight; a new one is accepted while the result register still waits.
// Commit stalls while the result register is full and rsp_tready is low.
// Synchronous reset clears the bucket valid bits, queue pointers and counters.
`default_nettype none
module session_log_rate_limiter (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // [5:0] session_index, [53:6] now_ms, [85:54] event_tag
   input  wire logic [slrl_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // [0] op, [1] has_session
   input  wire logic [slrl_pkg::REQ_TUSER_W-1:0]     req_tuser,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // [31:0] taken_tag, [63:32] dropped_count, [95:64] limited_count, [104:96] queue_fill
   output logic      [slrl_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // [2:0] status
   output logic      [slrl_pkg::STATUS_W-1:0]        rsp_tuser,
   input  wire logic                                 csr_wen,
   input  wire logic [slrl_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [slrl_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import slrl_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type dp_status;

   slrl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (dp_status),
      .cmd        (cmd)
   );

   slrl_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (dp_status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

endmodule
`default_nettype wire
